@@ rtl/hpg_pkg.sv @@
// ----------------------------------------------------------------------------
// hpg_pkg
// Shared types and constants of the 2D Halton point generator (bases 2, 3).
// ----------------------------------------------------------------------------
package hpg_pkg;

    // Width of the point index and of each 0.F fixed-point coordinate
    localparam int INDEX_BITS = 31;
    localparam int FRAC_BITS  = 32;

    // Divide by three through a reciprocal: q = (idx * RECIP3) >> RECIP_SHIFT
    // is exact for every idx below 2^INDEX_BITS (rounding error stays below 2).
    localparam int RECIP_SHIFT = INDEX_BITS + 2;
    localparam logic [63:0] RECIP3_WIDE = ((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3;
    localparam logic [INDEX_BITS:0] RECIP3 = RECIP3_WIDE[INDEX_BITS:0];

    // Bits needed for 3^D, where D is the largest ternary digit count of an index
    function automatic int den_bits(input int n);
        logic [63:0] p;
        int          b;
        p = 64'd1;
        b = 0;
        while (p < (64'd1 << n))
        begin
            p = p * 64'd3;
        end
        while ((p >> b) != 64'd0)
        begin
            b = b + 1;
        end
        return b;
    endfunction

    localparam int DEN_W = den_bits(INDEX_BITS);
    localparam int CNT_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture a new index, clear the accumulators
        logic digit_step;  // peel off one ternary digit
        logic div_step;    // one restoring division step
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic idx_zero;    // no ternary digits left
        logic div_last;    // current division step is the final one
    } dp_sts_t;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIGIT  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

@@ rtl/hpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// hpg_ctrl
// Sequencer: load, ternary digit loop, fraction division loop, result beat.
// ----------------------------------------------------------------------------
module hpg_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  hpg_pkg::dp_sts_t sts,
    output hpg_pkg::dp_cmd_t cmd,
    output logic             busy,
    output logic             done
);

    hpg_pkg::state_t state_reg;
    hpg_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hpg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the phases and issue datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.digit_step = 1'b0;
        cmd.div_step   = 1'b0;
        unique case (state_reg)
            hpg_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = hpg_pkg::ST_DIGIT;
                end
            end
            hpg_pkg::ST_DIGIT:
            begin
                if (sts.idx_zero)
                begin
                    state_next = hpg_pkg::ST_DIVIDE;
                end
                else
                begin
                    cmd.digit_step = 1'b1;
                end
            end
            hpg_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = hpg_pkg::ST_DONE;
                end
            end
            hpg_pkg::ST_DONE:
            begin
                state_next = hpg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = hpg_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != hpg_pkg::ST_IDLE);
    assign done = (state_reg == hpg_pkg::ST_DONE);

endmodule

@@ rtl/hpg_datapath.sv @@
// ----------------------------------------------------------------------------
// hpg_datapath
// Bit mirror for x; ternary digit reversal and restoring division for y.
// ----------------------------------------------------------------------------
module hpg_datapath
(
    input  logic                               clk,
    input  hpg_pkg::dp_cmd_t                   cmd,
    input  logic [hpg_pkg::INDEX_BITS-1:0]     point_index,
    output hpg_pkg::dp_sts_t                   sts,
    output logic [hpg_pkg::FRAC_BITS-1:0]      coord_x,
    output logic [hpg_pkg::FRAC_BITS-1:0]      coord_y
);

    localparam int N  = hpg_pkg::INDEX_BITS;
    localparam int F  = hpg_pkg::FRAC_BITS;
    localparam int DW = hpg_pkg::DEN_W;
    localparam int CW = hpg_pkg::CNT_W;

    logic [N-1:0]     idx_reg;
    logic [DW-1:0]    numer_reg;   // reversed digits, then division remainder
    logic [DW-1:0]    denom_reg;   // 3 to the digit count
    logic [F-1:0]     x_reg;
    logic [F-1:0]     quot_reg;
    logic [CW-1:0]    cnt_reg;

    logic [F-1:0]     x_mirror;
    logic [2*N+1:0]   prod;
    logic [N-1:0]     quot3;
    logic [N+1:0]     dtmp;
    logic [1:0]       digit;
    logic [DW-1:0]    numer_acc;
    logic [DW:0]      rem_shift;
    logic [DW:0]      rem_diff;
    logic             rem_ge;

    // Mirror the index bits about the binary point
    always_comb
    begin
        x_mirror = '0;
        for (int k = 0; k < N; k++)
        begin
            if (k < F)
            begin
                x_mirror[F-1-k] = point_index[k];
            end
        end
    end

    // Split off the low ternary digit: quotient by reciprocal, digit by back-multiply
    assign prod      = (2*N+2)'(idx_reg) * (2*N+2)'(hpg_pkg::RECIP3);
    assign quot3     = prod[hpg_pkg::RECIP_SHIFT +: N];
    assign dtmp      = {2'b00, idx_reg} - {1'b0, quot3, 1'b0} - {2'b00, quot3};
    assign digit     = dtmp[1:0];
    assign numer_acc = {numer_reg[DW-2:0], 1'b0} + numer_reg + DW'(digit);

    // One restoring division step on the remainder
    assign rem_shift = {numer_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, denom_reg};
    assign rem_ge    = (rem_shift >= {1'b0, denom_reg});

    // Update the working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg   <= point_index;
            x_reg     <= x_mirror;
            numer_reg <= '0;
            denom_reg <= DW'(1);
            cnt_reg   <= '0;
        end
        else if (cmd.digit_step)
        begin
            idx_reg   <= quot3;
            numer_reg <= numer_acc;
            denom_reg <= {denom_reg[DW-2:0], 1'b0} + denom_reg;
        end
        else if (cmd.div_step)
        begin
            numer_reg <= rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
            quot_reg  <= {quot_reg[F-2:0], rem_ge};
            cnt_reg   <= cnt_reg + CW'(1);
        end
    end

    assign sts.idx_zero = (idx_reg == '0);
    assign sts.div_last = (cnt_reg == CW'(F - 1));
    assign coord_x      = x_reg;
    assign coord_y      = quot_reg;

endmodule

@@ rtl/halton_point_2d_generator.sv @@
// ----------------------------------------------------------------------------
// halton_point_2d_generator
// Returns the 2D Halton point (bases 2 and 3, unsigned 0.32) of an index.
// ----------------------------------------------------------------------------
//  channel   ports                      beat taken when
//  -------   -------------------------  -----------------------------
//  command   start, point_index         start high while busy is low
//  result    done, coord_x, coord_y     done high, one cycle per point
//
//  Each point runs through a load, a digit loop with one step per ternary
//  digit of the index (D digits, D in 0..20), 32 division steps and a result
//  beat. The digits are peeled by a divide-by-three unit (one digit per
//  cycle) and the fraction is formed by a one-bit-per-cycle restoring divider.
//  Reset (rst_n low, asynchronous) returns the sequencer to idle.
//  The receiver cannot stall: the result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module halton_point_2d_generator
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [hpg_pkg::INDEX_BITS-1:0]     point_index,
    output logic                               done,
    output logic [hpg_pkg::FRAC_BITS-1:0]      coord_x,
    output logic [hpg_pkg::FRAC_BITS-1:0]      coord_y
);

    hpg_pkg::dp_cmd_t cmd;
    hpg_pkg::dp_sts_t sts;

    // Sequence the phases
    hpg_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Compute both coordinates
    hpg_datapath u_datapath
    (
        .clk         (clk),
        .cmd         (cmd),
        .point_index (point_index),
        .sts         (sts),
        .coord_x     (coord_x),
        .coord_y     (coord_y)
    );

endmodule

@@ rtl/hpg_checker.sv @@
// ----------------------------------------------------------------------------
// hpg_checker
// Port-level checks of the command and result beats.
// ----------------------------------------------------------------------------
module hpg_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // Drop a result beat only while a point is in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result beat while idle");

    // Hold busy after an accepted command beat
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // Each result beat lasts one cycle and frees the block
    assert property (@(posedge clk) disable iff (!rst_n) done |=> (!done && !busy))
        else $error("result beat not followed by idle");

    // Busy only drops at the end of a result beat
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

endmodule

bind halton_point_2d_generator hpg_checker u_hpg_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
